// ===== sv/mis_pkg.sv =====
`timescale 1ns / 1ps
// mis_pkg: shared constants, types and codes of the merge insertion sorter
// no dependencies; used by the channel interfaces, the cell and the top level
package mis_pkg;

	localparam int MAX_ITEMS = 64;
	localparam int VALUE_W   = 31;
	localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

	typedef logic [VALUE_W-1:0] value_t;
	typedef logic [CNT_W-1:0]   count_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_SHIFT
	} cell_op_t;

	typedef enum logic {
		ST_FILL,
		ST_DRAIN
	} mis_state_t;

	// broadcast from the controller to every cell of the chain
	typedef struct packed {
		cell_op_t op;
		value_t   value;
	} cell_ctrl_t;

endpackage

// ===== sv/mis_item_if.sv =====
`timescale 1ns / 1ps
// mis_item_if: valid/ready channel carrying one input beat of a run
// depends on mis_pkg for the value width
interface mis_item_if;
	logic                      valid;
	logic                      ready;
	logic [mis_pkg::VALUE_W-1:0] value;
	logic                      last;

	modport source (output valid, output value, output last, input ready);
	modport sink   (input valid, input value, input last, output ready);
endinterface

// ===== sv/mis_result_if.sv =====
`timescale 1ns / 1ps
// mis_result_if: valid/ready channel carrying one sorted result beat
// depends on mis_pkg for the value width
interface mis_result_if;
	logic                      valid;
	logic                      ready;
	logic [mis_pkg::VALUE_W-1:0] sorted_value;
	logic                      end_of_run;
	logic                      overflow;

	modport source (output valid, output sorted_value, output end_of_run, output overflow,
		input ready);
	modport sink   (input valid, input sorted_value, input end_of_run, input overflow,
		output ready);
endinterface

// ===== sv/mis_cell.sv =====
`timescale 1ns / 1ps
// mis_cell: one slot of the insertion chain, holds a value and trades with neighbors
// depends on mis_pkg
module mis_cell (
	input  logic                clk,
	input  mis_pkg::cell_ctrl_t ctrl,
	input  logic                occupied,
	input  logic                tail,
	input  logic                left_gt,
	input  mis_pkg::value_t     left_value,
	input  mis_pkg::value_t     right_value,
	output logic                gt,
	output mis_pkg::value_t     value
);
	import mis_pkg::*;

	value_t value_q;

	// strictly greater, so an equal new value lands after the held ones
	assign gt    = occupied && (value_q > ctrl.value);
	assign value = value_q;

	always_ff @(posedge clk) begin
		case (ctrl.op)
			CELL_INSERT: begin
				if (gt || tail) begin
					value_q <= left_gt ? left_value : ctrl.value;
				end
			end
			CELL_SHIFT: begin
				value_q <= right_value;
			end
			default: begin
				value_q <= value_q;
			end
		endcase
	end

endmodule

// ===== sv/merge_insertion_sorter.sv =====
`timescale 1ns / 1ps
// merge_insertion_sorter: top level, insertion chain of mis_cell plus fill/drain control
// depends on mis_pkg, mis_item_if, mis_result_if and mis_cell
//
//   channel   dir   payload                               beat when
//   items     in    value[30:0], last                     valid && ready
//   results   out   sorted_value[30:0], end_of_run,       valid && ready
//                   overflow
//
// fill: one item beat per cycle; the value is broadcast to all cells and lands
//   in its sorted slot in the next cycle, larger values move one cell up; a
//   beat that finds the chain full is dropped and marks the run overflowed
// drain: after the last beat the chain shifts toward cell 0 through the output
//   register, one result per cycle unless stalled; no items taken while draining
// reset clears the fill count, the drop flag, the state and the output valid;
//   the cell contents need no reset since only filled cells are ever read
module merge_insertion_sorter (
	input logic          clk,
	input logic          arst_n,
	mis_item_if.sink     items,
	mis_result_if.source results
);
	import mis_pkg::*;

	mis_state_t state_q, state_d;
	count_t     count_q;      // kept items; counts down while draining
	logic       drop_q;       // some item of this run was dropped
	logic       out_valid_q;
	value_t     out_value_q;
	logic       out_eor_q;
	logic       out_ovf_q;

	logic       accept;
	logic       full;
	logic       load;
	cell_ctrl_t ctrl;

	logic   cell_gt    [MAX_ITEMS];
	value_t cell_value [MAX_ITEMS];

	assign full   = (count_q == CNT_W'(MAX_ITEMS));
	assign accept = items.valid && items.ready;
	// while draining, the output register takes a new result when empty or being emptied
	assign load   = (state_q == ST_DRAIN) && (!out_valid_q || results.ready);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_FILL: begin
				if (accept && items.last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (load && count_q == CNT_W'(1)) begin
					state_d = ST_FILL;
				end
			end
			default: begin
				state_d = ST_FILL;
			end
		endcase
	end

	// outputs of the controller
	always_comb begin
		items.ready = 1'b0;
		ctrl.op     = CELL_HOLD;
		ctrl.value  = items.value;
		case (state_q)
			ST_FILL: begin
				items.ready = 1'b1;
				if (accept && !full) begin
					ctrl.op = CELL_INSERT;
				end
			end
			ST_DRAIN: begin
				if (load) begin
					ctrl.op = CELL_SHIFT;
				end
			end
			default: begin
				ctrl.op = CELL_HOLD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_FILL;
			count_q     <= '0;
			drop_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				if (full) begin
					drop_q <= 1'b1;
				end else begin
					count_q <= count_q + CNT_W'(1);
				end
			end
			if (load) begin
				out_valid_q <= 1'b1;
				count_q     <= count_q - CNT_W'(1);
				// last result of the run: start the next run clean
				if (count_q == CNT_W'(1)) begin
					drop_q <= 1'b0;
				end
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (load) begin
			out_value_q <= cell_value[0];
			out_eor_q   <= (count_q == CNT_W'(1));
			out_ovf_q   <= drop_q;
		end
	end

	assign results.valid        = out_valid_q;
	assign results.sorted_value = out_value_q;
	assign results.end_of_run   = out_eor_q;
	assign results.overflow     = out_ovf_q;

	// the chain: cell 0 holds the smallest value
	for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
		logic   left_gt;
		value_t left_value;
		value_t right_value;

		if (i == 0) begin : g_head
			assign left_gt    = 1'b0;
			assign left_value = '0;
		end else begin : g_body
			assign left_gt    = cell_gt[i-1];
			assign left_value = cell_value[i-1];
		end

		if (i == MAX_ITEMS - 1) begin : g_end
			assign right_value = cell_value[i];
		end else begin : g_mid
			assign right_value = cell_value[i+1];
		end

		mis_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.occupied    (count_q > CNT_W'(i)),
			.tail        (count_q == CNT_W'(i)),
			.left_gt     (left_gt),
			.left_value  (left_value),
			.right_value (right_value),
			.gt          (cell_gt[i]),
			.value       (cell_value[i])
		);
	end

endmodule
